### design/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared constants and types of the Huffman bit packer: code table geometry,
// item kinds and the structs that pass between the table and the packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int SYMBOL_COUNT = 256;

	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int SYM_W   = 8;
	localparam int BYTE_W  = 8;
	localparam int ENTRY_W = CODE_W + LEN_W;
	localparam int TBL_AW  = $clog2(SYMBOL_COUNT);
	localparam int ACC_W   = CODE_W + BYTE_W;

	// Longest code that a table entry keeps.
	localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_ENCODE = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	typedef struct packed {
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [TBL_AW-1:0] addr;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} tbl_wr_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              trailer;
	} emit_t;

endpackage

### design/hbp_ram.sv
// ----------------------------------------------------------------------------
// hbp_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module hbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/hbp_table.sv
// ----------------------------------------------------------------------------
// hbp_table
// Code table: RAM of code words and lengths, with one valid bit per entry so
// that an entry never loaded reads as an absent, zero-length code.
// ----------------------------------------------------------------------------
module hbp_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hbp_pkg::tbl_wr_t          wr,
	input  logic                      rd_en,
	input  logic [hbp_pkg::TBL_AW-1:0] rd_addr,
	output hbp_pkg::entry_t           rd_entry
);

	logic [hbp_pkg::SYMBOL_COUNT-1:0] valid_q;
	logic                             rd_valid_q;
	logic [hbp_pkg::LEN_W-1:0]        len_sat;
	logic [hbp_pkg::CODE_W-1:0]       code_mask;
	hbp_pkg::entry_t                  wr_entry;
	logic [hbp_pkg::ENTRY_W-1:0]      ram_rdata;

	// Lengths beyond the cap saturate; code bits above the length are dropped.
	always_comb begin
		if (wr.len > hbp_pkg::LEN_W'(hbp_pkg::LEN_CAP)) begin
			len_sat = hbp_pkg::LEN_W'(hbp_pkg::LEN_CAP);
		end else begin
			len_sat = wr.len;
		end
		code_mask = ~({hbp_pkg::CODE_W{1'b1}} << len_sat);
		wr_entry.bits = wr.code & code_mask;
		wr_entry.len  = len_sat;
	end

	hbp_ram #(
		.WIDTH(hbp_pkg::ENTRY_W),
		.DEPTH(hbp_pkg::SYMBOL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_valid_q ? hbp_pkg::entry_t'(ram_rdata) : '0;

endmodule

### design/hbp_packer.sv
// ----------------------------------------------------------------------------
// hbp_packer
// Request sequencer and bit accumulator: issues table writes and lookups,
// appends looked-up codes to the pending byte and hands out finished bytes
// and the trailer one per cycle while the output takes them.
// ----------------------------------------------------------------------------
module hbp_packer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 kind,
	input  logic [hbp_pkg::SYM_W-1:0]  symbol,
	input  logic [hbp_pkg::CODE_W-1:0] code_bits,
	input  logic [hbp_pkg::LEN_W-1:0]  code_length,
	output hbp_pkg::tbl_wr_t           tbl_wr,
	output logic                       rd_en,
	output logic [hbp_pkg::TBL_AW-1:0] rd_addr,
	input  hbp_pkg::entry_t            rd_entry,
	output hbp_pkg::emit_t             emit,
	input  logic                       emit_take
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]                  state_q;
	logic [hbp_pkg::BYTE_W-1:0]  pending_q;
	logic [2:0]                  bf_q;
	logic [hbp_pkg::ACC_W-1:0]   acc_q;
	logic [2:0]                  nb_q;
	logic                        trl_pend_q;
	logic [3:0]                  trl_val_q;

	logic                        accept;
	logic                        sym_ok;
	logic [hbp_pkg::CODE_W-1:0]  code_l;
	logic [hbp_pkg::ACC_W-1:0]   acc_new;
	logic [hbp_pkg::ACC_W-1:0]   acc_rest;
	logic [hbp_pkg::LEN_W-1:0]   total;
	logic [2:0]                  nb_new;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign sym_ok   = {1'b0, symbol} < (hbp_pkg::SYM_W + 1)'(hbp_pkg::SYMBOL_COUNT);

	always_comb begin
		tbl_wr.en   = accept && (kind == hbp_pkg::KIND_LOAD) && sym_ok;
		tbl_wr.addr = symbol[hbp_pkg::TBL_AW-1:0];
		tbl_wr.code = code_bits;
		tbl_wr.len  = code_length;
	end

	assign rd_en   = accept && (kind == hbp_pkg::KIND_ENCODE) && sym_ok;
	assign rd_addr = symbol[hbp_pkg::TBL_AW-1:0];

	// The code is left-aligned and placed right after the bits already pending.
	always_comb begin
		code_l   = rd_entry.bits << (hbp_pkg::LEN_W'(hbp_pkg::CODE_W) - rd_entry.len);
		acc_new  = {pending_q, {hbp_pkg::CODE_W{1'b0}}}
		         | ({code_l, {hbp_pkg::BYTE_W{1'b0}}} >> bf_q);
		total    = hbp_pkg::LEN_W'(bf_q) + rd_entry.len;
		nb_new   = total[5:3];
		acc_rest = acc_new << {nb_new, 3'b000};
	end

	always_comb begin
		emit.valid = (state_q == S_EMIT);
		if (nb_q != 3'd0) begin
			emit.data    = acc_q[hbp_pkg::ACC_W-1 -: hbp_pkg::BYTE_W];
			emit.last    = (nb_q == 3'd1) && !trl_pend_q;
			emit.trailer = 1'b0;
		end else begin
			emit.data    = {4'd0, trl_val_q};
			emit.last    = 1'b1;
			emit.trailer = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pending_q  <= '0;
			bf_q       <= '0;
			acc_q      <= '0;
			nb_q       <= '0;
			trl_pend_q <= 1'b0;
			trl_val_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (rd_en) begin
						state_q <= S_LOOK;
					end else if (accept && (kind == hbp_pkg::KIND_END)) begin
						// Flush a partial byte, then the count of its valid bits.
						acc_q      <= {pending_q, {hbp_pkg::CODE_W{1'b0}}};
						nb_q       <= {2'b00, (bf_q != 3'd0)};
						trl_pend_q <= 1'b1;
						trl_val_q  <= (bf_q != 3'd0) ? {1'b0, bf_q} : 4'd8;
						pending_q  <= '0;
						bf_q       <= '0;
						state_q    <= S_EMIT;
					end
				end
				S_LOOK: begin
					acc_q      <= acc_new;
					nb_q       <= nb_new;
					trl_pend_q <= 1'b0;
					pending_q  <= acc_rest[hbp_pkg::ACC_W-1 -: hbp_pkg::BYTE_W];
					bf_q       <= total[2:0];
					state_q    <= (nb_new != 3'd0) ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (emit_take) begin
						if (nb_q != 3'd0) begin
							acc_q <= acc_q << hbp_pkg::BYTE_W;
							nb_q  <= nb_q - 3'd1;
						end else begin
							trl_pend_q <= 1'b0;
						end
						if (emit.last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### design/huffman_bit_packer_top.sv
// ----------------------------------------------------------------------------
// huffman_bit_packer_top
// Huffman code packer: loads a code table, appends looked-up codes MSB first
// into bytes and closes a stream with a valid-bit count trailer.
//
//   Channel  Direction  Handshake            Payload
//   in       sink       in_valid/in_stall    kind, symbol, code_bits, code_length
//   out      source     out_valid/out_stall  packed_byte, last_of_run, is_trailer
//
// A load request writes the table without leaving the idle state. An encode
// request reads the table, adds the code to the pending bits and then emits
// each finished byte (up to four); an end request emits its partial byte, if
// any, and the trailer. The output register sets the pace: one byte per cycle while out_stall is low.
// Reset clears the pending byte and marks every table entry as absent.
// ----------------------------------------------------------------------------
module huffman_bit_packer_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 kind,
	input  logic [hbp_pkg::SYM_W-1:0]  symbol,
	input  logic [hbp_pkg::CODE_W-1:0] code_bits,
	input  logic [hbp_pkg::LEN_W-1:0]  code_length,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [hbp_pkg::BYTE_W-1:0] packed_byte,
	output logic                       last_of_run,
	output logic                       is_trailer
);

	hbp_pkg::tbl_wr_t            tbl_wr;
	logic                        rd_en;
	logic [hbp_pkg::TBL_AW-1:0]  rd_addr;
	hbp_pkg::entry_t             rd_entry;
	hbp_pkg::emit_t              emit;
	logic                        emit_take;

	logic                        out_valid_q;
	logic [hbp_pkg::BYTE_W-1:0]  packed_byte_q;
	logic                        last_q;
	logic                        trailer_q;

	hbp_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	hbp_packer u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.symbol      (symbol),
		.code_bits   (code_bits),
		.code_length (code_length),
		.tbl_wr      (tbl_wr),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_entry    (rd_entry),
		.emit        (emit),
		.emit_take   (emit_take)
	);

	// The output register takes a new byte when it is empty or being drained.
	assign emit_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid && emit_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid && emit_take) begin
			packed_byte_q <= emit.data;
			last_q        <= emit.last;
			trailer_q     <= emit.trailer;
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_byte = packed_byte_q;
	assign last_of_run = last_q;
	assign is_trailer  = trailer_q;

endmodule
